@@ rtl/core/pidl_pkg.sv @@
// Shared widths, codes and defaults for the positional insert/delete list.
// Depends on nothing; imported by every module of the block.
package pidl_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = 4;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FRONT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEL_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

@@ rtl/core/positional_insert_delete_list.sv @@
// Top level of the positional insert/delete list: control sequencer,
// entry count and output register. Depends on pidl_pkg and pidl_ram.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_mode, i_position, i_value
//  out     | output    | o_out_valid / i_out_stall| o_status, o_count, o_element,
//          |           |                          | o_element_index, o_last
//
// Flow: an insert or delete shifts its entries, one entry per cycle on the single
//   RAM port pair; a rejected word goes straight to its result word, and a dump
//   reads its entries in order from the registered RAM read port.
// Reset: synchronous, active low; clears count, sequencer and output valid.
//   List contents are not cleared; only entries below the count are read.
// Stalls: a held output word only holds the sequencer when it has a new word
//   ready; a new input word is taken as soon as the sequencer is idle.
module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [POS_W-1:0]    i_position,
    input  logic signed [DATA_W-1:0]   i_value,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_count,
    output logic signed [DATA_W-1:0]   o_element,
    output logic [IDX_W-1:0]           o_element_index,
    output logic                       o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_DUMP  = 4'b0100,
        S_RES   = 4'b1000
    } t_state;

    // sequencer state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr,   n_ptr;    // insert: dest; delete: source; dump: index
    logic [CW-1:0]       r_p,     n_p;      // insert target position
    logic [DATA_W-1:0]   r_val,   n_val;
    logic                r_ins,   n_ins;    // shift direction: 1 up (insert), 0 down
    logic                r_pend,  n_pend;   // a RAM read is in flight for write-back
    logic [AW-1:0]       r_wdst,  n_wdst;
    logic [STATUS_W-1:0] r_res,   n_res;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic [DATA_W-1:0]   r_out_element, n_out_element;
    logic [IDX_W-1:0]    r_out_index, n_out_index;
    logic                r_out_last, n_out_last;

    // RAM port
    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;

    // decode helpers
    logic                in_acc, out_free, pos_neg, pos_gt, full;
    logic [POS_W-1:0]    pos_u, cnt8, ptr8;
    logic [CW-1:0]       p_ins, ptr_inc, ptr_dec;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign pos_u   = i_position;
    assign pos_neg = i_position[POS_W-1];
    assign cnt8    = POS_W'(r_count);
    assign ptr8    = POS_W'(r_ptr);
    assign pos_gt  = !pos_neg && (pos_u > cnt8);
    assign full    = (r_count == CW'(DEPTH));
    assign ptr_inc = r_ptr + CW'(1);
    assign ptr_dec = r_ptr - CW'(1);

    // Negative clamps to the front, beyond the count clamps to the end.
    always_comb begin
        if (pos_neg) begin
            p_ins = '0;
        end else if (pos_gt) begin
            p_ins = r_count;
        end else begin
            p_ins = CW'(pos_u);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_p      = r_p;
        n_val    = r_val;
        n_ins    = r_ins;
        n_pend   = r_pend;
        n_wdst   = r_wdst;
        n_res    = r_res;

        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;
        n_out_element = r_out_element;
        n_out_index   = r_out_index;
        n_out_last    = r_out_last;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wdst;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_INSERT: begin
                            if (full) begin
                                n_res   = ST_FULL;
                                n_state = S_RES;
                            end else begin
                                n_res   = pos_neg ? ST_FRONT : (pos_gt ? ST_END : ST_OK);
                                n_ins   = 1'b1;
                                n_ptr   = r_count;
                                n_p     = p_ins;
                                n_val   = i_value;
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        MODE_DELETE: begin
                            if (pos_neg || (pos_u >= cnt8)) begin
                                n_res   = ST_DEL_RANGE;
                                n_state = S_RES;
                            end else begin
                                n_res   = ST_OK;
                                n_ins   = 1'b0;
                                n_ptr   = CW'(pos_u) + CW'(1);
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_res   = ST_OK;
                                n_state = S_RES;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                n_ptr       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            // unused mode: dropped, no result
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // write back the word read last cycle
                if (r_pend) begin
                    ram_wr_en = 1'b1;
                end
                if (r_ins) begin
                    // walk down: read ptr-1, write it to ptr next cycle
                    if (r_ptr > r_p) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ptr_dec[AW-1:0];
                        n_pend      = 1'b1;
                        n_wdst      = r_ptr[AW-1:0];
                        n_ptr       = ptr_dec;
                    end else if (!r_pend) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_p[AW-1:0];
                        ram_wr_data = r_val;
                        n_count     = r_count + CW'(1);
                        n_state     = S_RES;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    // walk up: read ptr, write it to ptr-1 next cycle
                    if (r_ptr < r_count) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_ptr[AW-1:0];
                        n_pend      = 1'b1;
                        n_wdst      = ptr_dec[AW-1:0];
                        n_ptr       = ptr_inc;
                    end else if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        n_state = S_RES;
                    end else begin
                        n_pend = 1'b0;
                    end
                end
            end

            S_DUMP: begin
                // read data for r_ptr is valid here; prefetch the next entry
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = ST_OK;
                    n_out_count   = cnt8[COUNT_W-1:0];
                    n_out_element = ram_rd_data;
                    n_out_index   = ptr8[IDX_W-1:0];
                    n_out_last    = (ptr_inc == r_count);
                    if (ptr_inc == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ptr_inc[AW-1:0];
                        n_ptr       = ptr_inc;
                    end
                end
            end

            S_RES: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res;
                    n_out_count   = cnt8[COUNT_W-1:0];
                    n_out_element = '0;
                    n_out_index   = '0;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_p           <= n_p;
        r_val         <= n_val;
        r_ins         <= n_ins;
        r_wdst        <= n_wdst;
        r_res         <= n_res;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
        r_out_element <= n_out_element;
        r_out_index   <= n_out_index;
        r_out_last    <= n_out_last;
    end

    pidl_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_count         = r_out_count;
    assign o_element       = r_out_element;
    assign o_element_index = r_out_index;
    assign o_last          = r_out_last;

endmodule

@@ rtl/core/pidl_ram.sv @@
// Simple dual-port RAM: one write port, one read port, registered read data.
// Depends on pidl_pkg for the word width and the default depth.
module pidl_ram
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/pidl_chk.sv @@
// Port-level checker for the positional insert/delete list, with its bind.
// Depends on pidl_pkg for widths and status codes.
module pidl_chk
    import pidl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [MODE_W-1:0]        i_mode,
    input logic signed [POS_W-1:0]  i_position,
    input logic signed [DATA_W-1:0] i_value,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [STATUS_W-1:0]      o_status,
    input logic [COUNT_W-1:0]       o_count,
    input logic signed [DATA_W-1:0] o_element,
    input logic [IDX_W-1:0]         o_element_index,
    input logic                     o_last
);

    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    // a stalled input word stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_mode)
            && $stable(i_position) && $stable(i_value))
        else $error("input word changed while stalled");

    // a held output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_count) && $stable(o_element)
            && $stable(o_element_index) && $stable(o_last))
        else $error("output word changed while stalled");

    // full is reported only when the list holds DEPTH entries
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> (o_count == DEPTH_CNT))
        else $error("full status with count below depth");

    // every non-ok result is a single, last word with no element
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK)
            |-> o_last && (o_element == '0) && (o_element_index == '0))
        else $error("error result carries element data or is not last");

    // a non-final dump word is followed by the next index
    a_dump_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last ##1 o_out_valid
            |-> (o_element_index == $past(o_element_index) + IDX_W'(1))
                && (o_count == $past(o_count)))
        else $error("dump words out of order");

endmodule

bind positional_insert_delete_list pidl_chk #(
    .DEPTH (DEPTH)
) u_pidl_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_mode          (i_mode),
    .i_position      (i_position),
    .i_value         (i_value),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_count         (o_count),
    .o_element       (o_element),
    .o_element_index (o_element_index),
    .o_last          (o_last)
);
